// File: design/pngcd_pkg.sv
package pngcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] FIELD_BYTES   = 32'd4;

  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;

  typedef struct packed {
    logic [WORD_W-1:0] chunk_length;
    logic [WORD_W-1:0] chunk_type;
    logic              is_critical;
    logic [WORD_W-1:0] data_offset;
    logic [WORD_W-1:0] stored_crc;
    logic [WORD_W-1:0] computed_crc;
    logic              crc_match;
  } pngcd_result_t;

  typedef struct packed {
    logic valid;
    logic pending;
    logic advance;
  } pngcd_stage_ctl_t;

  function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/pngcd_in_if.sv
interface pngcd_in_if import pngcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: design/pngcd_out_if.sv
interface pngcd_out_if import pngcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] chunk_length;
  logic [WORD_W-1:0] chunk_type;
  logic              is_critical;
  logic [WORD_W-1:0] data_offset;
  logic [WORD_W-1:0] stored_crc;
  logic [WORD_W-1:0] computed_crc;
  logic              crc_match;

  modport source (output valid, output chunk_length, output chunk_type, output is_critical,
                  output data_offset, output stored_crc, output computed_crc,
                  output crc_match, input ready);
  modport sink   (input valid, input chunk_length, input chunk_type, input is_critical,
                  input data_offset, input stored_crc, input computed_crc,
                  input crc_match, output ready);
endinterface

// File: design/png_chunk_deframer_crc32_core.sv
// Channel     Direction  Payload
// in_stream   sink       stream_byte (8 bits)
// out_result  source     chunk_length, chunk_type, is_critical, data_offset,
//                        stored_crc, computed_crc, crc_match
//
// One byte is accepted per cycle unless a stalled result holds the parse stage.
// The last CRC byte is registered in the input stage, then its result is registered in the output stage.
// The byte-wide CRC update in the parse stage sets the cycle time.
// Reset is synchronous and active low and puts the parser at a chunk boundary.
// A stalled result holds the parse stage only when its last CRC byte is waiting.
module png_chunk_deframer_crc32_core import pngcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pngcd_in_if.sink    in_stream,
  pngcd_out_if.source out_result
);

  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              slot_free;
  logic              pending;
  pngcd_result_t     result;
  pngcd_stage_ctl_t  ctl;

  always_comb begin
    ctl.valid   = stage_valid;
    ctl.pending = pending;
    ctl.advance = !stage_valid || !pending || slot_free;
  end

  pngcd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_stream),
    .advance     (ctl.advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  pngcd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte),
    .advance     (ctl.advance),
    .pending     (pending),
    .result      (result)
  );

  pngcd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .slot_free  (slot_free),
    .out_result (out_result)
  );

endmodule

// File: design/pngcd_in_stage.sv
module pngcd_in_stage import pngcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pngcd_in_if.sink          in_stream,
  input  logic              advance,
  output logic              stage_valid,
  output logic [BYTE_W-1:0] stage_byte
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              in_fire;

  assign in_stream.ready = !valid_r || advance;
  assign in_fire         = in_stream.valid && in_stream.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_stream.stream_byte;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

// File: design/pngcd_parser.sv
module pngcd_parser import pngcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stage_valid,
  input  logic [BYTE_W-1:0] stage_byte,
  input  logic              advance,
  output logic              pending,
  output pngcd_result_t     result
);

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_CRC    = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [WORD_W-1:0] length_r, length_nxt;
  logic [WORD_W-1:0] type_r, type_nxt;
  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] stored_crc_r, stored_crc_nxt;
  logic [WORD_W-1:0] pos_r, pos_nxt;
  logic [WORD_W-1:0] offset_r, offset_nxt;
  logic              fire;
  logic              last_byte;
  logic [WORD_W-1:0] crc_upd;
  logic [WORD_W-1:0] stored_full;
  logic [WORD_W-1:0] computed;

  assign fire        = stage_valid && advance;
  assign last_byte   = (bytes_left_r == {{(WORD_W-1){1'b0}}, 1'b1});
  assign pending     = stage_valid && (phase_r == PH_CRC) && last_byte;
  assign crc_upd     = crc32_byte(crc_r, stage_byte);
  assign stored_full = {stored_crc_r[WORD_W-BYTE_W-1:0], stage_byte};
  assign computed    = crc_r ^ CRC_ALL_ONES;

  always_comb begin
    result.chunk_length = length_r;
    result.chunk_type   = type_r;
    result.is_critical  = (type_r[WORD_W-1 -: BYTE_W] >= ASCII_UPPER_A) &&
                          (type_r[WORD_W-1 -: BYTE_W] <= ASCII_UPPER_Z);
    result.data_offset  = offset_r;
    result.stored_crc   = stored_full;
    result.computed_crc = computed;
    result.crc_match    = (stored_full == computed);
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    length_nxt     = length_r;
    type_nxt       = type_r;
    crc_nxt        = crc_r;
    stored_crc_nxt = stored_crc_r;
    pos_nxt        = pos_r;
    offset_nxt     = offset_r;
    if (fire) begin
      pos_nxt        = pos_r + WORD_W'(1);
      bytes_left_nxt = bytes_left_r - WORD_W'(1);
      case (phase_r)
        PH_LENGTH: begin
          length_nxt = {length_r[WORD_W-BYTE_W-1:0], stage_byte};
          if (last_byte) begin
            phase_nxt      = PH_TYPE;
            bytes_left_nxt = FIELD_BYTES;
            crc_nxt        = CRC_ALL_ONES;
          end
        end
        PH_TYPE: begin
          type_nxt = {type_r[WORD_W-BYTE_W-1:0], stage_byte};
          crc_nxt  = crc_upd;
          if (last_byte) begin
            offset_nxt = pos_r + WORD_W'(1);
            if (length_r == '0) begin
              phase_nxt      = PH_CRC;
              bytes_left_nxt = FIELD_BYTES;
            end else begin
              phase_nxt      = PH_DATA;
              bytes_left_nxt = length_r;
            end
          end
        end
        PH_DATA: begin
          crc_nxt = crc_upd;
          if (last_byte) begin
            phase_nxt      = PH_CRC;
            bytes_left_nxt = FIELD_BYTES;
          end
        end
        PH_CRC: begin
          stored_crc_nxt = stored_full;
          if (last_byte) begin
            phase_nxt      = PH_LENGTH;
            bytes_left_nxt = FIELD_BYTES;
          end
        end
        default: begin
          phase_nxt = PH_LENGTH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LENGTH;
      bytes_left_r <= FIELD_BYTES;
      length_r     <= '0;
      type_r       <= '0;
      crc_r        <= CRC_ALL_ONES;
      stored_crc_r <= '0;
      pos_r        <= '0;
      offset_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      length_r     <= length_nxt;
      type_r       <= type_nxt;
      crc_r        <= crc_nxt;
      stored_crc_r <= stored_crc_nxt;
      pos_r        <= pos_nxt;
      offset_r     <= offset_nxt;
    end
  end

endmodule

// File: design/pngcd_out_stage.sv
module pngcd_out_stage import pngcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  pngcd_stage_ctl_t ctl,
  input  pngcd_result_t    result,
  output logic             slot_free,
  pngcd_out_if.source      out_result
);

  logic          valid_r;
  logic          valid_nxt;
  pngcd_result_t data_r;
  logic          load;

  assign slot_free = !valid_r || out_result.ready;
  assign load      = ctl.valid && ctl.pending && ctl.advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_result.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_result.valid        = valid_r;
  assign out_result.chunk_length = data_r.chunk_length;
  assign out_result.chunk_type   = data_r.chunk_type;
  assign out_result.is_critical  = data_r.is_critical;
  assign out_result.data_offset  = data_r.data_offset;
  assign out_result.stored_crc   = data_r.stored_crc;
  assign out_result.computed_crc = data_r.computed_crc;
  assign out_result.crc_match    = data_r.crc_match;

endmodule

// File: tb/png_chunk_deframer_crc32_core_tb.sv
`timescale 1ns / 100ps

module png_chunk_deframer_crc32_core_tb import pngcd_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 1250;
  localparam int unsigned TAIL_DATA     = 40;
  localparam int unsigned MAX_DATA      = 300;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_START    = 700;
  localparam int unsigned HOLD_CYCLES   = 500;

  typedef enum logic [1:0] {PH_LENGTH, PH_TYPE, PH_DATA, PH_CRC} field_phase_t;
  typedef enum logic [1:0] {CRC_GOOD, CRC_GIVEN, CRC_FLIP, CRC_SWAP} crc_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] ctype;
    logic [BYTE_W-1:0] fill;
    crc_kind_t         crc_kind;
    logic [WORD_W-1:0] given_crc;
    logic              typed;
    pngcd_result_t     want;
  } chunk_row_t;

  localparam int unsigned DIRECTED_ROWS = 2;
  localparam chunk_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'd0, 32'h4945_4E44, 8'h00, CRC_GIVEN, 32'hAE42_6082, 1'b1,
      '{32'd0, 32'h4945_4E44, 1'b1, 32'd8, 32'hAE42_6082, 32'hAE42_6082, 1'b1}},
    '{32'd1, 32'hFFFF_FFFF, 8'h00, CRC_GIVEN, 32'h0000_0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  pngcd_in_if  in_ch ();
  pngcd_out_if out_ch ();

  png_chunk_deframer_crc32_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_result (out_ch)
  );

  always #5 clk = ~clk;

  logic [BYTE_W-1:0] stream_q [$];
  chunk_row_t        chunk_plan_q [$];
  pngcd_result_t     chunk_expect_q [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned bad_crc_seen = 0;
  int unsigned critical_seen = 0;
  int unsigned bytes_taken  = 0;
  int unsigned cycle_count  = 0;

  field_phase_t      ph           = PH_LENGTH;
  logic [WORD_W-1:0] bytes_to_go  = FIELD_BYTES;
  logic [WORD_W-1:0] len_acc      = '0;
  logic [WORD_W-1:0] type_acc     = '0;
  logic [WORD_W-1:0] crc_acc      = CRC_ALL_ONES;
  logic [WORD_W-1:0] stored_acc   = '0;
  logic [WORD_W-1:0] pos          = '0;
  logic [WORD_W-1:0] first_data   = '0;

  function automatic logic [WORD_W-1:0] crc32_fold(input logic [WORD_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] r;
    logic              fb;
    r = acc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[WORD_W-1:1]} ^ (fb ? CRC_POLY_REFL : '0);
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] random_letter(input bit upper);
    return (upper ? ASCII_UPPER_A : 8'h61) + BYTE_W'($urandom_range(0, 25));
  endfunction

  function automatic chunk_row_t random_chunk_plan();
    chunk_row_t  row;
    int unsigned pick;
    row = '0;
    pick = $urandom_range(0, 99);
    if (pick < 12)      row.length = 0;
    else if (pick < 75) row.length = $urandom_range(1, 16);
    else if (pick < 95) row.length = $urandom_range(17, 64);
    else                row.length = $urandom_range(65, MAX_DATA);
    case ($urandom_range(0, 7))
      0:       row.ctype[31:24] = ASCII_UPPER_A - 8'd1;
      1:       row.ctype[31:24] = ASCII_UPPER_A;
      2:       row.ctype[31:24] = ASCII_UPPER_Z;
      3:       row.ctype[31:24] = ASCII_UPPER_Z + 8'd1;
      4, 5:    row.ctype[31:24] = random_letter(1'b1);
      6:       row.ctype[31:24] = random_letter(1'b0);
      default: row.ctype[31:24] = BYTE_W'($urandom_range(0, 255));
    endcase
    for (int i = 0; i < 3; i++) begin
      row.ctype[i*8 +: 8] = $urandom_range(0, 1) ? random_letter(1'($urandom_range(0, 1)))
                                                 : BYTE_W'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0:       row.crc_kind = CRC_FLIP;
      1:       row.crc_kind = CRC_SWAP;
      2:       row.crc_kind = CRC_GIVEN;
      default: row.crc_kind = CRC_GOOD;
    endcase
    row.given_crc = $urandom;
    return row;
  endfunction

  task automatic append_chunk(input chunk_row_t row, input bit random_data,
                              input int unsigned data_limit);
    logic [WORD_W-1:0] crc;
    logic [WORD_W-1:0] stored;
    logic [BYTE_W-1:0] b;
    crc = CRC_ALL_ONES;
    for (int i = 3; i >= 0; i--) stream_q.push_back(row.length[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) begin
      b = row.ctype[i*8 +: 8];
      stream_q.push_back(b);
      crc = crc32_fold(crc, b);
    end
    for (int unsigned n = 0; n < row.length && n < data_limit; n++) begin
      b = random_data ? BYTE_W'($urandom_range(0, 255)) : row.fill;
      stream_q.push_back(b);
      crc = crc32_fold(crc, b);
    end
    if (row.length <= data_limit) begin
      crc = crc ^ CRC_ALL_ONES;
      case (row.crc_kind)
        CRC_GOOD:  stored = crc;
        CRC_GIVEN: stored = row.given_crc;
        CRC_FLIP:  stored = crc ^ (32'h1 << $urandom_range(0, 31));
        default:   stored = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
      endcase
      for (int i = 3; i >= 0; i--) stream_q.push_back(stored[i*8 +: 8]);
      chunk_plan_q.push_back(row);
    end
  endtask

  // Mirrors the parser one accepted byte at a time and queues a chunk summary on
  // the last CRC byte. Directed rows with a typed-in summary replace the computed one.
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    pngcd_result_t res;
    chunk_row_t    plan;
    case (ph)
      PH_LENGTH: begin
        len_acc = {len_acc[23:0], b};
        bytes_to_go--;
        if (bytes_to_go == 0) begin
          ph          = PH_TYPE;
          bytes_to_go = FIELD_BYTES;
          crc_acc     = CRC_ALL_ONES;
        end
      end
      PH_TYPE: begin
        type_acc = {type_acc[23:0], b};
        crc_acc  = crc32_fold(crc_acc, b);
        bytes_to_go--;
        if (bytes_to_go == 0) begin
          first_data = pos + 1;
          if (len_acc == 0) begin
            ph          = PH_CRC;
            bytes_to_go = FIELD_BYTES;
          end else begin
            ph          = PH_DATA;
            bytes_to_go = len_acc;
          end
        end
      end
      PH_DATA: begin
        crc_acc = crc32_fold(crc_acc, b);
        bytes_to_go--;
        if (bytes_to_go == 0) begin
          ph          = PH_CRC;
          bytes_to_go = FIELD_BYTES;
        end
      end
      default: begin
        stored_acc = {stored_acc[23:0], b};
        bytes_to_go--;
        if (bytes_to_go == 0) begin
          res.chunk_length = len_acc;
          res.chunk_type   = type_acc;
          res.is_critical  = (type_acc[31:24] >= ASCII_UPPER_A) &&
                             (type_acc[31:24] <= ASCII_UPPER_Z);
          res.data_offset  = first_data;
          res.stored_crc   = stored_acc;
          res.computed_crc = crc_acc ^ CRC_ALL_ONES;
          res.crc_match    = (res.stored_crc == res.computed_crc);
          plan = '0;
          if (chunk_plan_q.size() > 0) plan = chunk_plan_q.pop_front();
          chunk_expect_q.push_back(plan.typed ? plan.want : res);
          ph          = PH_LENGTH;
          bytes_to_go = FIELD_BYTES;
        end
      end
    endcase
    pos = pos + 1;
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    pngcd_result_t want;
    if (chunk_expect_q.size() == 0) begin
      $display("%0t: result with no chunk pending, expected none, got length %h type %h",
               $time, out_ch.chunk_length, out_ch.chunk_type);
      mismatches++;
    end else begin
      want = chunk_expect_q.pop_front();
      compare_field("chunk_length", want.chunk_length, out_ch.chunk_length);
      compare_field("chunk_type", want.chunk_type, out_ch.chunk_type);
      compare_field("is_critical", want.is_critical, out_ch.is_critical);
      compare_field("data_offset", want.data_offset, out_ch.data_offset);
      compare_field("stored_crc", want.stored_crc, out_ch.stored_crc);
      compare_field("computed_crc", want.computed_crc, out_ch.computed_crc);
      compare_field("crc_match", want.crc_match, out_ch.crc_match);
      results_seen++;
      if (!want.crc_match) bad_crc_seen++;
      if (want.is_critical) critical_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.stream_byte);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d chunk summaries outstanding.",
               cycle_count, chunk_expect_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver changes its stall pattern now and then, and holds off for one long
  // stretch so that a finished chunk backs up and the input stalls.
  initial begin
    int unsigned rx_cycle;
    int unsigned mode;
    rx_cycle = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 97 == 0) mode = $urandom_range(0, 3);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ((rx_cycle % 5) < 2);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    chunk_row_t  tail;
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap_left;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.stream_byte = '0;

    for (int r = 0; r < DIRECTED_ROWS; r++) append_chunk(DIRECTED[r], 1'b0, MAX_DATA);
    while (stream_q.size() < RANDOM_BYTES) append_chunk(random_chunk_plan(), 1'b1, MAX_DATA);
    tail = random_chunk_plan();
    tail.length = 32'hFFFF_FFFF;
    append_chunk(tail, 1'b1, TAIL_DATA);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idx = 0;
    burst_left = $urandom_range(1, 48);
    gap_left = 0;
    while (idx < stream_q.size()) begin
      @(negedge clk);
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.stream_byte <= BYTE_W'($urandom_range(0, 255));
        gap_left--;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.stream_byte <= stream_q[idx];
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            9:             gap_left = $urandom_range(10, 30);
            default:       gap_left = $urandom_range(1, 4);
          endcase
        end
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (chunk_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes; checked %0d chunk summaries, %0d critical, %0d with bad CRC.",
             bytes_taken, results_seen, critical_seen, bad_crc_seen);
    $display("Included a long result stall and an unfinished chunk of maximum length.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
